// ===== hw/rtl/diss_pkg.sv =====
// Shared types and constants for the device/inode seen-set block.
// No dependencies; imported by diss_bucket_idx, the core and both bench files.
package diss_pkg;

    localparam int DATA_W      = 32;
    localparam int OUTCOME_W   = 2;
    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_NEW  = 2'd0,
        OUTCOME_SEEN = 2'd1,
        OUTCOME_FULL = 2'd2
    } outcome_t;

endpackage

// ===== hw/rtl/diss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module diss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/diss_bucket_idx.sv =====
// Bucket index unit: inode modulo BUCKET_COUNT.
// Depends on diss_pkg. A power-of-two count is a mask; otherwise a reciprocal multiply.
module diss_bucket_idx #(
    parameter int BUCKET_COUNT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [diss_pkg::DATA_W-1:0]     inode,
    output logic                            done,
    output logic [$clog2(BUCKET_COUNT)-1:0] bucket
);
    import diss_pkg::*;

    localparam int BW = $clog2(BUCKET_COUNT);
    localparam bit IS_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);

    generate
        if (IS_POW2)
        begin : g_mask
            logic          done_reg;
            logic [BW-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else if (start)
                begin
                    done_reg <= 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= inode[BW-1:0];
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
        else
        begin : g_recip
            // floor(2^SHIFT / BUCKET_COUNT) fits in 32 bits because BUCKET_COUNT lies above
            // 2^(BW-1). The quotient estimate is then at most one below the true quotient,
            // so one conditional subtract finishes the remainder.
            localparam int SHIFT = DATA_W - 1 + BW;
            localparam longint unsigned RECIP = (64'd1 << SHIFT) / BUCKET_COUNT;
            localparam logic [DATA_W-1:0] RECIP_W = DATA_W'(RECIP);

            logic [2:0]          stage_reg;
            logic                done_reg;
            logic [DATA_W-1:0]   word_reg;
            logic [2*DATA_W-1:0] prod_reg;
            logic [BW:0]         raw_reg;
            logic [BW-1:0]       rem_reg;
            logic [DATA_W-1:0]   quot;
            logic [DATA_W-1:0]   qb;
            logic [DATA_W-1:0]   diff;
            logic [BW:0]         raw_sub;

            assign quot    = DATA_W'(prod_reg >> SHIFT);
            assign qb      = quot * DATA_W'(BUCKET_COUNT);
            assign diff    = word_reg - qb;
            assign raw_sub = raw_reg - (BW + 1)'(BUCKET_COUNT);

            // One stage per cycle: multiply, back-multiply and subtract, correct.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg <= '0;
                    done_reg  <= 1'b0;
                end
                else if (start)
                begin
                    stage_reg <= 3'b001;
                    done_reg  <= 1'b0;
                end
                else
                begin
                    stage_reg <= {stage_reg[1:0], 1'b0};
                    if (stage_reg[2])
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    word_reg <= inode;
                end
                if (stage_reg[0])
                begin
                    prod_reg <= {{DATA_W{1'b0}}, word_reg} * {{DATA_W{1'b0}}, RECIP_W};
                end
                if (stage_reg[1])
                begin
                    raw_reg <= diff[BW:0];
                end
                if (stage_reg[2])
                begin
                    rem_reg <= (raw_reg >= (BW + 1)'(BUCKET_COUNT)) ? raw_sub[BW-1:0]
                                                                    : raw_reg[BW-1:0];
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
    endgenerate

endmodule

// ===== hw/rtl/device_inode_seen_set_core.sv =====
// Top level of the device/inode seen-set: sequencer, table valid bits, shared comparator.
// Depends on diss_pkg, diss_ram (tags, bucket fill counts, keys) and diss_bucket_idx.
//
// Usage:
// An s_axis transaction carries a device and an inode. The block finds the table tagged
// with that device (claiming the lowest free one), takes bucket inode mod BUCKET_COUNT
// and scans its filled slots. One m_axis transaction follows per input: NEW when the
// inode was stored, SEEN when already present, FULL when no table or slot was free.
//
// Timing: one item at a time; s_axis_tready is high only while idle. One 32-bit equality
// comparator serves the tag scan and the slot scan, each compare behind a registered RAM
// read. Per item: a tag read and compare for each valid table scanned (a read alone when
// a table is claimed), the bucket address and a read of its fill count, a read and
// compare for each filled slot and a closing read when none matches, then the finish step
// that loads the output register; a tag scan that finds every table taken by other
// devices goes straight to the finish step. The finish step returns the block to idle,
// where the next item is taken. A bucket count that is not a power of two takes its
// index from a reciprocal multiply, which can stretch the address step.
//
// Reset: valid bits clear at once; then the fill counts of all TABLE_COUNT*BUCKET_COUNT
// buckets are zeroed one per cycle with s_axis_tready low. A stalled receiver holds the
// result in the output register; the next item can still be accepted, and its result
// waits in the last step until that register frees up.
module device_inode_seen_set_core #(
    parameter int TABLE_COUNT      = 4,
    parameter int BUCKET_COUNT     = 256,
    parameter int SLOTS_PER_BUCKET = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [diss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [31:0] device, [63:32] inode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [diss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // [1:0] outcome, [7:2] zero
);
    import diss_pkg::*;

    localparam int TW         = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int BW         = $clog2(BUCKET_COUNT);
    localparam int FILL_DEPTH = TABLE_COUNT * BUCKET_COUNT;
    localparam int FA_W       = $clog2(FILL_DEPTH);
    localparam int KEY_DEPTH  = FILL_DEPTH * SLOTS_PER_BUCKET;
    localparam int KA_W       = $clog2(KEY_DEPTH);
    localparam int FILL_W     = $clog2(SLOTS_PER_BUCKET + 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAG_RD,
        ST_TAG_CMP,
        ST_ADDR,
        ST_FILL_RD,
        ST_FILL_WAIT,
        ST_SLOT_RD,
        ST_SLOT_CMP,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [FA_W-1:0]     clr_cnt_reg;
    logic [TABLE_COUNT-1:0] valid_reg;
    logic [TW-1:0]       tag_idx_reg;
    logic [TW-1:0]       table_reg;
    logic [DATA_W-1:0]   device_reg;
    logic [DATA_W-1:0]   inode_reg;
    logic [FA_W-1:0]     bidx_reg;
    logic [KA_W-1:0]     base_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   slot_reg;
    outcome_t            result_reg;
    logic                out_valid_reg;
    outcome_t            out_outcome_reg;

    logic                accept;
    logic                rem_done;
    logic [BW-1:0]       rem_bucket;
    logic [DATA_W-1:0]   tag_rdata;
    logic [DATA_W-1:0]   key_rdata;
    logic [FILL_W-1:0]   fill_rdata;
    logic [KA_W-1:0]     key_addr;
    logic [DATA_W-1:0]   cmp_a;
    logic [DATA_W-1:0]   cmp_b;
    logic                cmp_hit;
    logic                tag_we;
    logic                append;
    logic                fill_we;
    logic [FA_W-1:0]     fill_waddr;
    logic [FILL_W-1:0]   fill_wdata;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // The one comparator of the block: device against a stored tag during the table
    // scan, inode against a stored key during the bucket scan.
    assign cmp_a   = (state_reg == ST_TAG_CMP) ? tag_rdata : key_rdata;
    assign cmp_b   = (state_reg == ST_TAG_CMP) ? device_reg : inode_reg;
    assign cmp_hit = (cmp_a == cmp_b);

    // Tables are claimed lowest first and never released, so the valid tables form a
    // prefix: the first invalid table met in the scan is the one to claim.
    assign tag_we = (state_reg == ST_TAG_RD) && !valid_reg[tag_idx_reg];

    // The scan reached the end of the filled slots without a match and room is left.
    assign append = (state_reg == ST_SLOT_RD) && (slot_reg == fill_reg)
                    && (fill_reg != FILL_W'(SLOTS_PER_BUCKET));

    assign key_addr   = base_reg + KA_W'(slot_reg);
    assign fill_we    = (state_reg == ST_CLEAR) || append;
    assign fill_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : bidx_reg;
    assign fill_wdata = (state_reg == ST_CLEAR) ? '0 : fill_reg + 1'b1;

    diss_bucket_idx #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_bucket_idx (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .inode  (s_axis_tdata[IN_TDATA_W-1:DATA_W]),
        .done   (rem_done),
        .bucket (rem_bucket)
    );

    diss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_idx_reg),
        .wdata (device_reg),
        .raddr (tag_idx_reg),
        .rdata (tag_rdata)
    );

    diss_ram #(
        .WIDTH (FILL_W),
        .DEPTH (FILL_DEPTH)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (bidx_reg),
        .rdata (fill_rdata)
    );

    diss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (append),
        .waddr (key_addr),
        .wdata (inode_reg),
        .raddr (key_addr),
        .rdata (key_rdata)
    );

    // Sequencer, valid bits and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            valid_reg       <= '0;
            tag_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_outcome_reg <= OUTCOME_NEW;
        end
        else
        begin
            // The output register empties on a handshake unless the finish step refills it.
            if (m_axis_tready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == FA_W'(FILL_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    tag_idx_reg <= '0;
                    if (accept)
                    begin
                        state_reg <= ST_TAG_RD;
                    end
                end
                ST_TAG_RD:
                begin
                    if (!valid_reg[tag_idx_reg])
                    begin
                        valid_reg[tag_idx_reg] <= 1'b1;
                        state_reg              <= ST_ADDR;
                    end
                    else
                    begin
                        state_reg <= ST_TAG_CMP;
                    end
                end
                ST_TAG_CMP:
                begin
                    if (cmp_hit)
                    begin
                        state_reg <= ST_ADDR;
                    end
                    else if (tag_idx_reg == TW'(TABLE_COUNT - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        tag_idx_reg <= tag_idx_reg + 1'b1;
                        state_reg   <= ST_TAG_RD;
                    end
                end
                ST_ADDR:
                begin
                    if (rem_done)
                    begin
                        state_reg <= ST_FILL_RD;
                    end
                end
                ST_FILL_RD:
                begin
                    state_reg <= ST_FILL_WAIT;
                end
                ST_FILL_WAIT:
                begin
                    state_reg <= ST_SLOT_RD;
                end
                ST_SLOT_RD:
                begin
                    if (slot_reg == fill_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_SLOT_CMP;
                    end
                end
                ST_SLOT_CMP:
                begin
                    if (cmp_hit)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_SLOT_RD;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_outcome_reg <= result_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item payload: captured operands, addresses and the verdict being formed.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    device_reg <= s_axis_tdata[DATA_W-1:0];
                    inode_reg  <= s_axis_tdata[IN_TDATA_W-1:DATA_W];
                end
            end
            ST_TAG_RD:
            begin
                table_reg <= tag_idx_reg;
            end
            ST_TAG_CMP:
            begin
                result_reg <= OUTCOME_FULL;
            end
            ST_ADDR:
            begin
                bidx_reg <= FA_W'(table_reg) * FA_W'(BUCKET_COUNT) + FA_W'(rem_bucket);
            end
            ST_FILL_RD:
            begin
                base_reg <= KA_W'(bidx_reg) * KA_W'(SLOTS_PER_BUCKET);
            end
            ST_FILL_WAIT:
            begin
                fill_reg <= fill_rdata;
                slot_reg <= '0;
            end
            ST_SLOT_RD:
            begin
                result_reg <= append ? OUTCOME_NEW : OUTCOME_FULL;
            end
            ST_SLOT_CMP:
            begin
                result_reg <= OUTCOME_SEEN;
                slot_reg   <= slot_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUTCOME_W){1'b0}}, out_outcome_reg};

    // A key is only ever appended into a bucket that still has room.
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        append |-> (fill_reg < FILL_W'(SLOTS_PER_BUCKET)))
        else $error("key appended into a full bucket");

    // Claiming a table sets its valid bit on the next edge.
    a_claim_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tag_we |=> valid_reg[$past(tag_idx_reg)])
        else $error("claimed table not marked valid");

    // An accepted item always starts with the table scan.
    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_TAG_RD))
        else $error("accepted item did not start the table scan");

    // The result register only ever holds one of the defined outcome codes.
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[OUTCOME_W-1:0] == OUTCOME_NEW)
                           || (m_axis_tdata[OUTCOME_W-1:0] == OUTCOME_SEEN)
                           || (m_axis_tdata[OUTCOME_W-1:0] == OUTCOME_FULL)))
        else $error("undefined outcome code on the output");

endmodule

// ===== bench/diss_outcome_checker.sv =====
// Outcome checker for the device/inode seen-set: watches both streams and scores results.
// Depends on diss_pkg for outcome_t; instantiated beside the block by the bench top.
`timescale 1ns / 1ps

module diss_outcome_checker #(
    parameter int TABLE_COUNT      = 4,
    parameter int BUCKET_COUNT     = 256,
    parameter int SLOTS_PER_BUCKET = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [diss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [31:0] device, [63:32] inode
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [diss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [1:0] outcome, [7:2] zero
    output int                                 mismatches,
    output int                                 outstanding
);
    import diss_pkg::*;

    localparam int BUCKETS_TOTAL = TABLE_COUNT * BUCKET_COUNT;

    // Shadow copy of the set contents.
    logic        table_used [TABLE_COUNT];
    logic [31:0] table_tag  [TABLE_COUNT];
    int          bucket_fill [BUCKETS_TOTAL];
    logic [31:0] slot_key   [BUCKETS_TOTAL * SLOTS_PER_BUCKET];

    outcome_t pending_outcomes [$];

    // Looks the inode up in the device's table and stores it when absent.
    function automatic outcome_t lookup_and_insert(input logic [31:0] dev,
                                                   input logic [31:0] ino);
        int tbl;
        int bkt;
        int fill;
        tbl = -1;
        for (int t = 0; t < TABLE_COUNT; t++)
            if (tbl < 0 && table_used[t] && table_tag[t] == dev)
                tbl = t;
        // No tag matched: claim the lowest free table with empty buckets.
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            if (tbl < 0 && !table_used[t])
            begin
                table_used[t] = 1'b1;
                table_tag[t]  = dev;
                for (int b = 0; b < BUCKET_COUNT; b++)
                    bucket_fill[t * BUCKET_COUNT + b] = 0;
                tbl = t;
            end
        end
        if (tbl < 0)
            return OUTCOME_FULL;
        bkt  = tbl * BUCKET_COUNT + int'(ino % BUCKET_COUNT);
        fill = bucket_fill[bkt];
        for (int i = 0; i < fill; i++)
            if (slot_key[bkt * SLOTS_PER_BUCKET + i] == ino)
                return OUTCOME_SEEN;
        if (fill >= SLOTS_PER_BUCKET)
            return OUTCOME_FULL;
        slot_key[bkt * SLOTS_PER_BUCKET + fill] = ino;
        bucket_fill[bkt] = fill + 1;
        return OUTCOME_NEW;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TABLE_COUNT; t++)
                table_used[t] = 1'b0;
            pending_outcomes.delete();
            mismatches = 0;
        end
        else
        begin
            // Predict first so that the queue is current before any result is scored.
            if (s_axis_tvalid && s_axis_tready)
                pending_outcomes.push_back(lookup_and_insert(s_axis_tdata[31:0],
                                                             s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result %0d arrived with no transaction pending",
                                 $realtime, m_axis_tdata[1:0]);
                end
                else
                begin
                    outcome_t want;
                    want = pending_outcomes.pop_front();
                    if (m_axis_tdata[OUTCOME_W-1:0] !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] outcome mismatch: expected %0d (%s), got %0d",
                                     $realtime, want, want.name(),
                                     m_axis_tdata[OUTCOME_W-1:0]);
                    end
                end
            end
        end
        outstanding = pending_outcomes.size();
    end

endmodule

// ===== bench/tb_device_inode_seen_set_core.sv =====
// Bench top for device_inode_seen_set_core: clock, reset, stimulus, pacing and verdict.
// Depends on diss_pkg, the block itself and diss_outcome_checker for scoring.
`timescale 1ns / 1ps

module tb_device_inode_seen_set_core;
    import diss_pkg::*;

    localparam int TABLE_COUNT      = 4;
    localparam int BUCKET_COUNT     = 256;
    localparam int SLOTS_PER_BUCKET = 16;

    // Random lookups after the directed opening, and a window at the end: from the first
    // multiple of 100 inside it, the remaining 125 lookups run with neither side idling.
    localparam int RANDOM_ITEMS = 1125;
    localparam int QUIET_TAIL   = 150;

    // Cycles without any transaction before the run is declared hung. The block's
    // reset sweep of the fill counts is the longest legal silence, longer than one
    // lookup plus the longest stall on each side.
    localparam int HANG_LIMIT   = 5000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata = '0;   // [31:0] device, [63:32] inode
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;        // [1:0] outcome, [7:2] zero

    int mismatches;
    int outstanding;

    // Pacing knobs, changed by the stimulus every hundred lookups. A value of
    // zero gives a stretch with no idling on that side.
    int tx_gap_pct  = 0;
    int rx_stall_pct = 0;
    int stall_left  = 0;
    int quiet_count = 0;

    // The four devices that end up owning all tables, the extremes among them.
    logic [31:0] device_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                     32'hA5A5_A5A5, 32'h5A5A_5A5A};
    // Inodes sent earlier, reused to provoke repeated lookups.
    logic [31:0] recent_inodes [$];

    always #5 clk = ~clk;

    device_inode_seen_set_core #(
        .TABLE_COUNT      (TABLE_COUNT),
        .BUCKET_COUNT     (BUCKET_COUNT),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    diss_outcome_checker #(
        .TABLE_COUNT      (TABLE_COUNT),
        .BUCKET_COUNT     (BUCKET_COUNT),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) outcome_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Receiver back-pressure: stalls come in bursts of random length. Changing
    // tready at the falling edge keeps it stable around every rising edge.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Hang detection: any cycle with a transaction on either stream resets the count.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= HANG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one lookup, optionally after an idle burst, and returns once the
    // block has taken the transaction. Valid stays high into the next call when
    // no gap follows, so it is only ever written once per falling edge.
    task automatic send_lookup(input logic [31:0] dev, input logic [31:0] ino);
        int gap;
        gap = (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) ?
              $urandom_range(1, 11) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ino, dev};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int          roll;
        logic [31:0] dev;
        logic [31:0] ino;

        // Reset is held low from the start and released once; the block then clears its
        // fill counts on its own with tready low, which send_lookup simply waits out.
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed opening with full-rate pacing on both sides.
        send_lookup(32'h0000_0000, 32'h0000_0000);   // claims the first table
        send_lookup(32'h0000_0000, 32'h0000_0000);   // same inode again: seen
        send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // all-ones device and inode
        send_lookup(32'hFFFF_FFFF, 32'h0000_0000);
        send_lookup(32'h0000_0000, 32'hFFFF_FFFF);   // other device's inode, own table
        send_lookup(32'hA5A5_A5A5, 32'h0000_0100);
        send_lookup(32'h5A5A_5A5A, 32'h0000_0100);   // last free table claimed
        send_lookup(32'h1234_5678, 32'h0000_0001);   // every table in use: full
        // Fill bucket 3 of the first table, overflow it, then hit its first
        // and its last slot.
        for (int k = 0; k <= SLOTS_PER_BUCKET; k++)
            send_lookup(32'h0000_0000, k * BUCKET_COUNT + 3);
        send_lookup(32'h0000_0000, 32'h0000_0003);
        send_lookup(32'h0000_0000, (SLOTS_PER_BUCKET - 1) * BUCKET_COUNT + 3);

        // Random part: mostly the owning devices, a few random devices that can
        // never get a table, repeated inodes, and inodes crowded into a handful
        // of buckets so that those buckets run full.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                if (n >= RANDOM_ITEMS - QUIET_TAIL)
                begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end
                else
                begin
                    roll = $urandom_range(0, 2);
                    tx_gap_pct   = (roll == 0) ? 0 : (roll == 1) ? 15 : 45;
                    roll = $urandom_range(0, 2);
                    rx_stall_pct = (roll == 0) ? 0 : (roll == 1) ? 15 : 45;
                end
            end

            roll = $urandom_range(0, 99);
            dev  = (roll < 12) ? 32'($urandom()) : device_pool[$urandom_range(0, 3)];

            roll = $urandom_range(0, 99);
            if (roll < 35 && recent_inodes.size() > 0)
            begin
                ino = recent_inodes[$urandom_range(0, recent_inodes.size() - 1)];
            end
            else
            begin
                ino = $urandom();
                if (roll < 80)
                    ino[7:0] = 8'($urandom_range(0, 7));
                if (recent_inodes.size() < 64)
                    recent_inodes.push_back(ino);
                else
                    recent_inodes[$urandom_range(0, 63)] = ino;
            end
            send_lookup(dev, ino);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // Drain: every expected result must arrive (the hang watchdog bounds this),
        // then a margin longer than one lookup catches any stray extra result.
        while (outstanding != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/diss_pkg.sv
hw/rtl/diss_ram.sv
hw/rtl/diss_bucket_idx.sv
hw/rtl/device_inode_seen_set_core.sv
bench/diss_outcome_checker.sv
bench/tb_device_inode_seen_set_core.sv
